// ===== design/scr_pkg.sv =====
// Shared types, widths and constants of the square corner rotator.
`default_nettype none

package scr_pkg;

  // Field widths
  localparam int COORD_W    = 16;
  localparam int ANGLE_BITS = 16;
  localparam int SIZE_W     = 12;
  localparam int VIDX_W     = 2;

  // APB register file
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_SQUARE_SIZE = '0;
  localparam logic [SIZE_W-1:0]    SIZE_RESET      = SIZE_W'(16);

  // CORDIC: x and y in Q2.30, angles in Q0.32 turns
  localparam int TURN_W       = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam logic [TURN_W-1:0]        TURN_EIGHTH = TURN_W'(32'h2000_0000);
  localparam logic signed [TURN_W-1:0] CORDIC_X0   = TURN_W'(652032874);
  localparam logic signed [TURN_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
    32'sd21354465,  32'sd10679838,  32'sd5340245,   32'sd2670163,  32'sd1335087,
    32'sd667544,    32'sd333772,    32'sd166886,    32'sd83443,    32'sd41722,
    32'sd20861,     32'sd10430,     32'sd5215,      32'sd2608,     32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,       32'sd41,
    32'sd20,        32'sd10,        32'sd5,         32'sd3,        32'sd1
  };

  // Q1.15 trig values held in 17 bits so that +1.0 is exact
  localparam int FRAC    = 15;
  localparam int Q15_W   = FRAC + 2;
  localparam int Q15_ONE = 1 << FRAC;

  // Datapath widths after the trig stage
  localparam int HALF_W = SIZE_W - 1;
  localparam int PROD_W = HALF_W + 1 + Q15_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int QUO_W  = SUM_W - FRAC;
  localparam int PIV_W  = ((COORD_W > HALF_W + 1) ? COORD_W : HALF_W + 1) + 1;
  localparam int VTX_W  = ((QUO_W > PIV_W) ? QUO_W : PIV_W) + 1;

  localparam logic [VIDX_W-1:0] VIDX_LAST = '1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ANGLE_BITS-1:0]     angle_t;
  typedef logic [SIZE_W-1:0]         size_t;
  typedef logic [VIDX_W-1:0]         vidx_t;
  typedef logic signed [Q15_W-1:0]   q15_t;

  typedef struct packed {
    logic signed [TURN_W-1:0] x;
    logic signed [TURN_W-1:0] y;
    logic signed [TURN_W-1:0] z;
    coord_t                   ox;
    coord_t                   oy;
    logic [1:0]               quad;
  } cordic_t;

endpackage

`default_nettype wire

// ===== design/scr_if.sv =====
// Valid/ready channels for corner requests and rotated vertices.
`default_nettype none

interface scr_in_if;
  import scr_pkg::*;
  logic   valid;
  logic   ready;
  coord_t origin_x;
  coord_t origin_y;
  angle_t angle;
  modport source (output valid, origin_x, origin_y, angle, input ready);
  modport sink   (input valid, origin_x, origin_y, angle, output ready);
endinterface

interface scr_out_if;
  import scr_pkg::*;
  logic   valid;
  logic   ready;
  vidx_t  vertex_index;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   last_vertex;
  modport source (output valid, vertex_index, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_index, vertex_x, vertex_y, last_vertex, output ready);
endinterface

`default_nettype wire

// ===== design/square_corner_rotator.sv =====
// Vertices: the four vertices of one input leave one a cycle while vertex_o.ready allows it.
// The single vertex output carries four transfers per input.
// Pipeline: input stage, 30 CORDIC stages (one step each), trig, multiply, prep, output register.
// The whole pipeline holds while the prep stage still has vertices left to send.
// Reset: clears stage valid bits, vertex counter and output valid; square_size returns to 16.
`default_nettype none

module square_corner_rotator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  scr_in_if.sink                           item_i,
  scr_out_if.source                        vertex_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [scr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [scr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [scr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import scr_pkg::*;

  localparam int NSTAGE = CORDIC_STEPS + 4;
  localparam int S_PRP  = CORDIC_STEPS + 3;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam logic signed [TURN_W:0]  Q15_RND   = (TURN_W+1)'(Q15_ONE / 2);
  localparam logic signed [TURN_W:0]  Q15_POS   = (TURN_W+1)'(Q15_ONE);
  localparam logic signed [TURN_W:0]  Q15_NEG   = -Q15_POS;
  localparam logic signed [SUM_W-1:0] FRAC_MASK = SUM_W'(Q15_ONE - 1);
  localparam logic signed [VTX_W-1:0] VTX_HI    =
    {{(VTX_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [VTX_W-1:0] VTX_LO    = ~VTX_HI;
  localparam coord_t COORD_HI = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_LO = ~COORD_HI;

  function automatic cordic_t cordic_step(cordic_t s, logic [STEP_W-1:0] i);
    logic signed [TURN_W-1:0] x;
    logic signed [TURN_W-1:0] y;
    logic signed [TURN_W-1:0] z;
    logic signed [TURN_W-1:0] xs;
    logic signed [TURN_W-1:0] ys;
    cordic_t r;
    x  = s.x;
    y  = s.y;
    z  = s.z;
    xs = x >>> i;
    ys = y >>> i;
    r  = s;
    if (!z[TURN_W-1]) begin
      r.x = x - ys;
      r.y = y + xs;
      r.z = z - ATAN_TURN[i];
    end else begin
      r.x = x + ys;
      r.y = y - xs;
      r.z = z + ATAN_TURN[i];
    end
    return r;
  endfunction

  function automatic q15_t to_q15(logic signed [TURN_W-1:0] v);
    logic signed [TURN_W:0] t;
    t = $signed({v[TURN_W-1], v}) + Q15_RND;
    t = t >>> FRAC;
    if (t > Q15_POS) t = Q15_POS;
    if (t < Q15_NEG) t = Q15_NEG;
    return t[Q15_W-1:0];
  endfunction

  // Divide by 2^FRAC, rounding toward zero.
  function automatic logic signed [QUO_W-1:0] trunc_q15(logic signed [SUM_W-1:0] n);
    logic signed [SUM_W-1:0] t;
    t = n + (n[SUM_W-1] ? FRAC_MASK : '0);
    return t[SUM_W-1:FRAC];
  endfunction

  function automatic coord_t place(logic signed [QUO_W-1:0] q, logic signed [PIV_W-1:0] p);
    logic signed [VTX_W-1:0] v;
    v = $signed({{(VTX_W-QUO_W){q[QUO_W-1]}}, q}) + $signed({{(VTX_W-PIV_W){p[PIV_W-1]}}, p});
    if (v > VTX_HI) return COORD_HI;
    if (v < VTX_LO) return COORD_LO;
    return v[COORD_W-1:0];
  endfunction

  // ---------------- configuration ----------------
  size_t                  size_q, size_d;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic [HALF_W-1:0]      half;
  logic                   odd;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_SQUARE_SIZE) ?
                   {{(APB_DATA_W-SIZE_W){1'b0}}, size_q} : '0;
  assign half    = size_q[SIZE_W-1:1];
  assign odd     = size_q[0];

  always_comb begin
    size_d = size_q;
    if (psel && penable && pwrite && pready && (reg_idx == REG_SQUARE_SIZE)) begin
      size_d = pwdata[SIZE_W-1:0];
    end
  end

  // ---------------- flow control ----------------
  logic [NSTAGE-1:0] vld_q, vld_d;
  vidx_t             k_q, k_d;
  logic              ovld_q, ovld_d;
  logic              out_load, fire, done, adv;

  assign out_load     = !ovld_q || vertex_o.ready;
  assign fire         = vld_q[S_PRP] && out_load;
  assign done         = fire && (k_q == VIDX_LAST);
  assign adv          = !vld_q[S_PRP] || done;
  assign item_i.ready = adv;

  always_comb begin
    vld_d  = vld_q;
    k_d    = k_q;
    ovld_d = ovld_q;
    if (adv) begin
      vld_d = {vld_q[NSTAGE-2:0], item_i.valid};
    end
    if (fire) begin
      k_d = vidx_t'(k_q + 1'b1);
    end
    if (out_load) begin
      ovld_d = vld_q[S_PRP];
    end
  end

  // ---------------- CORDIC ----------------
  cordic_t                  cor_q [CORDIC_STEPS+1];
  cordic_t                  cor_d [CORDIC_STEPS+1];
  logic [TURN_W-1:0]        turn, turn_off;

  always_comb begin
    turn     = {item_i.angle, {(TURN_W-ANGLE_BITS){1'b0}}};
    turn_off = turn + TURN_EIGHTH;
    cor_d[0].x    = CORDIC_X0;
    cor_d[0].y    = '0;
    cor_d[0].z    = $signed({2'b00, turn_off[TURN_W-3:0]}) - $signed(TURN_EIGHTH);
    cor_d[0].ox   = item_i.origin_x;
    cor_d[0].oy   = item_i.origin_y;
    cor_d[0].quad = turn_off[TURN_W-1:TURN_W-2];
    for (int i = 1; i <= CORDIC_STEPS; i++) begin
      cor_d[i] = cordic_step(cor_q[i-1], STEP_W'(i - 1));
    end
  end

  // ---------------- trig: round and restore quadrant ----------------
  q15_t   cs_d, sn_d, cs_q, sn_q;
  q15_t   c_r, s_r;
  coord_t tox_q, toy_q;

  always_comb begin
    c_r = to_q15(cor_q[CORDIC_STEPS].x);
    s_r = to_q15(cor_q[CORDIC_STEPS].y);
    case (cor_q[CORDIC_STEPS].quad)
      QUAD_0: begin
        cs_d = c_r;
        sn_d = s_r;
      end
      QUAD_1: begin
        cs_d = -s_r;
        sn_d = c_r;
      end
      QUAD_2: begin
        cs_d = -c_r;
        sn_d = -s_r;
      end
      default: begin
        cs_d = s_r;
        sn_d = -c_r;
      end
    endcase
  end

  // ---------------- multiply: half side times sin and cos ----------------
  logic signed [PROD_W-1:0] hc_d, hs_d, hc_q, hs_q;
  q15_t                     mcs_q, msn_q;
  logic signed [PIV_W-1:0]  px_d, py_d, mpx_q, mpy_q;
  logic signed [HALF_W:0]   half_s;

  always_comb begin
    half_s = $signed({1'b0, half});
    hc_d   = half_s * cs_q;
    hs_d   = half_s * sn_q;
    px_d   = $signed({{(PIV_W-COORD_W){tox_q[COORD_W-1]}}, tox_q}) +
             $signed({{(PIV_W-HALF_W){1'b0}}, half});
    py_d   = $signed({{(PIV_W-COORD_W){toy_q[COORD_W-1]}}, toy_q}) +
             $signed({{(PIV_W-HALF_W){1'b0}}, half});
  end

  // ---------------- prep: terms for the near and far edge ----------------
  // Far edge offset is size - half, one more than half for an odd size.
  logic signed [PROD_W-1:0] nc_d, ns_d, bc_d, bs_d, nc_q, ns_q, bc_q, bs_q;
  logic signed [PIV_W-1:0]  ppx_q, ppy_q;

  always_comb begin
    nc_d = -hc_q;
    ns_d = -hs_q;
    bc_d = hc_q + (odd ? $signed({{(PROD_W-Q15_W){mcs_q[Q15_W-1]}}, mcs_q}) : '0);
    bs_d = hs_q + (odd ? $signed({{(PROD_W-Q15_W){msn_q[Q15_W-1]}}, msn_q}) : '0);
  end

  // ---------------- vertex ----------------
  logic signed [PROD_W-1:0] tx_c, tx_s, ty_c, ty_s;
  logic signed [SUM_W-1:0]  num_x, num_y;
  coord_t                   vx_d, vy_d, vx_q, vy_q;
  vidx_t                    vi_q;
  logic                     vlast_q;

  always_comb begin
    tx_c  = k_q[0] ? bc_q : nc_q;
    tx_s  = k_q[0] ? bs_q : ns_q;
    ty_c  = k_q[1] ? bc_q : nc_q;
    ty_s  = k_q[1] ? bs_q : ns_q;
    num_x = $signed({tx_c[PROD_W-1], tx_c}) - $signed({ty_s[PROD_W-1], ty_s});
    num_y = $signed({tx_s[PROD_W-1], tx_s}) + $signed({ty_c[PROD_W-1], ty_c});
    vx_d  = place(trunc_q15(num_x), ppx_q);
    vy_d  = place(trunc_q15(num_y), ppy_q);
  end

  assign vertex_o.valid        = ovld_q;
  assign vertex_o.vertex_index = vi_q;
  assign vertex_o.vertex_x     = vx_q;
  assign vertex_o.vertex_y     = vy_q;
  assign vertex_o.last_vertex  = vlast_q;

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
      vld_q  <= '0;
      k_q    <= '0;
      ovld_q <= 1'b0;
    end else begin
      size_q <= size_d;
      vld_q  <= vld_d;
      k_q    <= k_d;
      ovld_q <= ovld_d;
    end
  end

  // Advance all stages together; hold while the prep stage has vertices left to send.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cor_q <= cor_d;
      cs_q  <= cs_d;
      sn_q  <= sn_d;
      tox_q <= cor_q[CORDIC_STEPS].ox;
      toy_q <= cor_q[CORDIC_STEPS].oy;
      hc_q  <= hc_d;
      hs_q  <= hs_d;
      mcs_q <= cs_q;
      msn_q <= sn_q;
      mpx_q <= px_d;
      mpy_q <= py_d;
      nc_q  <= nc_d;
      ns_q  <= ns_d;
      bc_q  <= bc_d;
      bs_q  <= bs_d;
      ppx_q <= mpx_q;
      ppy_q <= mpy_q;
    end
    if (fire) begin
      vi_q    <= k_q;
      vx_q    <= vx_d;
      vy_q    <= vy_d;
      vlast_q <= (k_q == VIDX_LAST);
    end
  end

endmodule

`default_nettype wire
